// File: rtl/kpc_pkg.sv
package kpc_pkg;

    // APB register file
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_LIMIT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_EN    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG_EN     = 2'd3;

    // hold counter and limits
    localparam int LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] HOLD_MAX        = 8'hFF;
    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 8'd80;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 8'd100;

    // events raised by one key in one scan tick
    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } key_event_t;

endpackage

// File: rtl/kpc_key.sv
module kpc_key (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         pressed,
    input  logic [kpc_pkg::LIMIT_W-1:0]  short_limit,
    input  logic [kpc_pkg::LIMIT_W-1:0]  long_limit,
    output kpc_pkg::key_event_t          events
);

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_CONFIRM = 2'd1;
    localparam logic [1:0] PHASE_HELD    = 2'd2;

    logic [1:0]                  phase_reg, phase_next;
    logic [kpc_pkg::LIMIT_W-1:0] hold_reg, hold_next;
    logic                        armed_reg, armed_next;

    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        armed_next = armed_reg;
        events     = '0;
        unique case (phase_reg)
            PHASE_CONFIRM: begin
                phase_next = pressed ? PHASE_HELD : PHASE_IDLE;
            end
            PHASE_HELD: begin
                if (!pressed && (hold_reg < short_limit)) begin
                    phase_next      = PHASE_IDLE;
                    events.short_ev = 1'b1;
                end else if (!pressed && (hold_reg > short_limit)) begin
                    phase_next = PHASE_IDLE;
                end else if (hold_reg != kpc_pkg::HOLD_MAX) begin
                    // release exactly at the limit lands here too: stay held
                    hold_next = hold_reg + 1'b1;
                end
                if (pressed && (hold_next > long_limit) && armed_reg) begin
                    events.long_ev = 1'b1;
                    armed_next     = 1'b0;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                if (pressed) begin
                    phase_next = PHASE_CONFIRM;
                    hold_next  = '0;
                    armed_next = 1'b1;
                end else begin
                    phase_next = PHASE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_IDLE;
            hold_reg  <= '0;
            armed_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            armed_reg <= armed_next;
        end
    end

    a_sat_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PHASE_HELD && hold_reg == kpc_pkg::HOLD_MAX)
        |=> hold_reg == kpc_pkg::HOLD_MAX)
        else $error("hold counter left saturation while held");

    a_press_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PHASE_IDLE && pressed)
        |=> (phase_reg == PHASE_CONFIRM && armed_reg && hold_reg == '0))
        else $error("press in idle did not start a confirmed, armed press");

    a_long_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && events.long_ev) |=> !armed_reg)
        else $error("long event left the key armed");

endmodule

// File: rtl/key_press_classifier.sv
// key_press_classifier
//
// Classifies key presses into short and long events for NUM_KEYS keys.
// Input channel (s_valid/s_ready/s_key_levels): one request per scan tick,
// bit i is the level of key i, 0 pressed and 1 released.
// Result channel (m_valid/m_ready/m_short_events/m_long_events): exactly one
// result per request, holding the short and long events of that tick, masked
// by the per-key enables.
// Configuration: APB port, registers at byte addresses 0x0 short_limit,
// 0x4 long_limit, 0x8 short enable mask, 0xC long enable mask; pready is
// always high. Write only while no request is in flight.
// Path: an accepted request is registered in the input register, then the
// per-key update loads its result into the result register.
// Throughput: one request per cycle while m_ready stays high; each key's
// state machine updates once per tick, so ticks stream back to back.
// Stall: while the receiver holds m_ready low, the result register holds and
// the input register still takes one more request; s_ready then drops.
// Reset (aresetn low, synchronous): all keys go idle, counters and arming
// clear, limits return to 80 and 100, enables to zero, both channels empty.
module key_press_classifier #(
    parameter int NUM_KEYS = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [NUM_KEYS-1:0]          s_key_levels,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [NUM_KEYS-1:0]          m_short_events,
    output logic [NUM_KEYS-1:0]          m_long_events,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpc_pkg::DATA_W-1:0]   pwdata,
    output logic [kpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [kpc_pkg::LIMIT_W-1:0]   short_limit_reg;
    logic [kpc_pkg::LIMIT_W-1:0]   long_limit_reg;
    logic [NUM_KEYS-1:0]           short_en_reg;
    logic [NUM_KEYS-1:0]           long_en_reg;
    logic                          cfg_write;
    logic [kpc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[kpc_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_limit_reg <= kpc_pkg::SHORT_LIMIT_RST;
            long_limit_reg  <= kpc_pkg::LONG_LIMIT_RST;
            short_en_reg    <= '0;
            long_en_reg     <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                kpc_pkg::REG_SHORT_LIMIT: short_limit_reg <= pwdata[kpc_pkg::LIMIT_W-1:0];
                kpc_pkg::REG_LONG_LIMIT:  long_limit_reg  <= pwdata[kpc_pkg::LIMIT_W-1:0];
                kpc_pkg::REG_SHORT_EN:    short_en_reg    <= pwdata[NUM_KEYS-1:0];
                kpc_pkg::REG_LONG_EN:     long_en_reg     <= pwdata[NUM_KEYS-1:0];
                default: ;
            endcase
        end
    end

    // Read back: zero-extend each register to the bus width
    always_comb begin
        unique case (cfg_idx)
            kpc_pkg::REG_SHORT_LIMIT: prdata = kpc_pkg::DATA_W'(short_limit_reg);
            kpc_pkg::REG_LONG_LIMIT:  prdata = kpc_pkg::DATA_W'(long_limit_reg);
            kpc_pkg::REG_SHORT_EN:    prdata = kpc_pkg::DATA_W'(short_en_reg);
            kpc_pkg::REG_LONG_EN:     prdata = kpc_pkg::DATA_W'(long_en_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: holds one request, so a new tick is taken even
    // while the result register waits on the receiver
    // ------------------------------------------------------------------
    logic                in_valid_reg, in_valid_next;
    logic [NUM_KEYS-1:0] in_levels_reg;
    logic                out_free;
    logic                advance;
    logic                s_take;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload needs no reset; load on every accepted request
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_levels_reg <= s_key_levels;
        end
    end

    // ------------------------------------------------------------------
    // Per-key state machines: advance all keys on the same tick
    // ------------------------------------------------------------------
    kpc_pkg::key_event_t key_ev [NUM_KEYS];
    logic [NUM_KEYS-1:0] short_raw;
    logic [NUM_KEYS-1:0] long_raw;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        kpc_key u_key (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .step        (advance),
            .pressed     (!in_levels_reg[k]),
            .short_limit (short_limit_reg),
            .long_limit  (long_limit_reg),
            .events      (key_ev[k])
        );
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            short_raw[k] = key_ev[k].short_ev;
            long_raw[k]  = key_ev[k].long_ev;
        end
    end

    // ------------------------------------------------------------------
    // Result register: drop events of disabled keys
    // ------------------------------------------------------------------
    logic                m_valid_reg, m_valid_next;
    logic [NUM_KEYS-1:0] short_out_reg;
    logic [NUM_KEYS-1:0] long_out_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            short_out_reg <= short_raw & short_en_reg;
            long_out_reg  <= long_raw & long_en_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_short_events = short_out_reg;
    assign m_long_events  = long_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_short_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_short_events & ~$past(short_en_reg)) == '0)
        else $error("short event reported for a disabled key");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_short_events & m_long_events) == '0)
        else $error("one key gave short and long events in one tick");

    a_stall_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without both registers full");

endmodule
